>>> design/rfad_pkg.sv
// Shared types and constants for the RGBA frame absolute-difference compare unit.
// Used by the lane, merge and top-level modules; depends on nothing else.
`timescale 1ns / 1ps

package rfad_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int CHANNELS      = 4;

  localparam int POS_W      = $clog2(MAX_DIMENSION);
  localparam int SIZE_W     = 13;
  localparam int CH_W       = 2;
  localparam int ITEM_SUM_W = 8 + $clog2(CHANNELS);
  localparam int SUM_W      = 34;

  localparam logic [7:0]        TOL_RESET  = 8'd40;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd64;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_TOLERANCE    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef logic [7:0]            diff_t;
  typedef logic [CH_W-1:0]       ch_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [ITEM_SUM_W-1:0] item_sum_t;

  // Position of a pixel within its frame, and whether it closes the frame.
  typedef struct packed {
    pos_t col;
    pos_t row;
    logic last;
  } tag_t;

  // Per-pixel result of the merge stage.
  typedef struct packed {
    diff_t     peak;
    ch_t       ch;
    item_sum_t sum;
    tag_t      tag;
  } merged_t;

endpackage

>>> design/rfad_lane.sv
// One channel lane: registered absolute difference of two 8-bit samples.
// Depends on rfad_pkg.
`timescale 1ns / 1ps

module rfad_lane (
  input  logic          clk,
  input  logic          en,
  input  rfad_pkg::diff_t a,
  input  rfad_pkg::diff_t b,
  output rfad_pkg::diff_t diff_r
);

  rfad_pkg::diff_t diff_nxt;

  always_comb begin
    if (a > b) begin
      diff_nxt = a - b;
    end else begin
      diff_nxt = b - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
    end
  end

endmodule

>>> design/rfad_merge.sv
// Merge stage: combines the lane differences of one pixel into its peak,
// the lowest channel holding that peak, and the pixel's difference sum.
// Depends on rfad_pkg.
`timescale 1ns / 1ps

module rfad_merge (
  input  logic              clk,
  input  logic              en,
  input  rfad_pkg::diff_t   diffs [rfad_pkg::CHANNELS],
  input  rfad_pkg::tag_t    tag,
  output rfad_pkg::merged_t merged_r
);

  rfad_pkg::merged_t merged_nxt;

  always_comb begin
    merged_nxt.peak = diffs[0];
    merged_nxt.ch   = '0;
    merged_nxt.sum  = rfad_pkg::item_sum_t'(diffs[0]);
    merged_nxt.tag  = tag;
    // A strictly greater value is needed to move, so the lowest channel wins ties.
    for (int i = 1; i < rfad_pkg::CHANNELS; i++) begin
      if (diffs[i] > merged_nxt.peak) begin
        merged_nxt.peak = diffs[i];
        merged_nxt.ch   = rfad_pkg::ch_t'(i);
      end
      merged_nxt.sum = merged_nxt.sum + rfad_pkg::item_sum_t'(diffs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merged_r <= merged_nxt;
    end
  end

endmodule

>>> design/rgba_frame_abs_diff_compare_unit.sv
// A frame's last pixel passes the lane registers and the merge register before its result is registered.
// Throughput: one pixel pair per cycle; four difference lanes feed one merge stage
// and one accumulator, and input stalls only while a finished result waits and
// the next frame's last pixel is ready to leave the merge stage.
// Reset (rst_n, synchronous): pipeline empty, counters and frame state cleared,
// tolerance 40, frame size 64 x 64.
`timescale 1ns / 1ps

module rgba_frame_abs_diff_compare_unit (
  input  logic               clk,
  input  logic               rst_n,
  // Pixel pair input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_first_red,
  input  logic [7:0]         in_first_green,
  input  logic [7:0]         in_first_blue,
  input  logic [7:0]         in_first_alpha,
  input  logic [7:0]         in_second_red,
  input  logic [7:0]         in_second_green,
  input  logic [7:0]         in_second_blue,
  input  logic [7:0]         in_second_alpha,
  // Frame result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_peak_difference,
  output logic signed [12:0] out_peak_column,
  output logic signed [12:0] out_peak_row,
  output logic signed [2:0]  out_peak_channel,
  output logic [33:0]        out_difference_sum,
  output logic               out_within_tolerance,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int POS_W  = rfad_pkg::POS_W;
  localparam int SIZE_W = rfad_pkg::SIZE_W;

  // Configuration registers
  logic [7:0]        tol_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= rfad_pkg::TOL_RESET;
      width_r  <= rfad_pkg::SIZE_RESET;
      height_r <= rfad_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rfad_pkg::REG_TOLERANCE:    tol_r    <= pwdata[7:0];
        rfad_pkg::REG_FRAME_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        rfad_pkg::REG_FRAME_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rfad_pkg::REG_TOLERANCE:    prdata = {24'd0, tol_r};
      rfad_pkg::REG_FRAME_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, width_r};
      rfad_pkg::REG_FRAME_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, height_r};
      default:                    prdata = '0;
    endcase
  end

  // Pipeline control. Only a frame-closing pixel that cannot enter a full
  // output register holds the pipeline.
  logic s1_v_r, s2_v_r;
  logic hold, adv, in_acc, s2_fire;
  rfad_pkg::merged_t merged_r;

  assign hold     = s2_v_r && merged_r.tag.last && out_valid && out_stall;
  assign adv      = !hold;
  assign in_stall = hold;
  assign in_acc   = in_valid && !hold;
  assign s2_fire  = s2_v_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
    end
  end

  // Column and row counters; a size of zero acts as one, a size above the
  // maximum dimension acts as the maximum.
  rfad_pkg::pos_t col_r, row_r;
  rfad_pkg::pos_t last_col, last_row;
  rfad_pkg::tag_t tag_in;
  rfad_pkg::tag_t tag_s1_r;

  always_comb begin
    if (width_r == '0) begin
      last_col = '0;
    end else if (width_r > SIZE_W'(rfad_pkg::MAX_DIMENSION)) begin
      last_col = POS_W'(rfad_pkg::MAX_DIMENSION - 1);
    end else begin
      last_col = POS_W'(width_r - SIZE_W'(1));
    end
    if (height_r == '0) begin
      last_row = '0;
    end else if (height_r > SIZE_W'(rfad_pkg::MAX_DIMENSION)) begin
      last_row = POS_W'(rfad_pkg::MAX_DIMENSION - 1);
    end else begin
      last_row = POS_W'(height_r - SIZE_W'(1));
    end
    tag_in.col  = col_r;
    tag_in.row  = row_r;
    tag_in.last = (col_r >= last_col) && (row_r >= last_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_r >= last_col) begin
        col_r <= '0;
        if (row_r >= last_row) begin
          row_r <= '0;
        end else begin
          row_r <= row_r + POS_W'(1);
        end
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_s1_r <= tag_in;
    end
  end

  // Difference lanes
  rfad_pkg::diff_t first_arr  [4];
  rfad_pkg::diff_t second_arr [4];
  rfad_pkg::diff_t lane_diff  [rfad_pkg::CHANNELS];

  assign first_arr[0]  = in_first_red;
  assign first_arr[1]  = in_first_green;
  assign first_arr[2]  = in_first_blue;
  assign first_arr[3]  = in_first_alpha;
  assign second_arr[0] = in_second_red;
  assign second_arr[1] = in_second_green;
  assign second_arr[2] = in_second_blue;
  assign second_arr[3] = in_second_alpha;

  for (genvar g = 0; g < rfad_pkg::CHANNELS; g++) begin : g_lane
    rfad_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .a      (first_arr[g]),
      .b      (second_arr[g]),
      .diff_r (lane_diff[g])
    );
  end

  rfad_merge u_merge (
    .clk      (clk),
    .en       (adv),
    .diffs    (lane_diff),
    .tag      (tag_s1_r),
    .merged_r (merged_r)
  );

  // Frame accumulator
  rfad_pkg::diff_t run_peak_r, new_peak;
  logic            run_valid_r, new_valid;
  rfad_pkg::pos_t  run_col_r, run_row_r, new_col, new_row;
  rfad_pkg::ch_t   run_ch_r, new_ch;
  logic [rfad_pkg::SUM_W-1:0] run_sum_r, new_sum;

  always_comb begin
    new_sum = run_sum_r + rfad_pkg::SUM_W'(merged_r.sum);
    if (merged_r.peak > run_peak_r) begin
      new_peak  = merged_r.peak;
      new_valid = 1'b1;
      new_col   = merged_r.tag.col;
      new_row   = merged_r.tag.row;
      new_ch    = merged_r.ch;
    end else begin
      new_peak  = run_peak_r;
      new_valid = run_valid_r;
      new_col   = run_col_r;
      new_row   = run_row_r;
      new_ch    = run_ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_peak_r  <= '0;
      run_valid_r <= 1'b0;
      run_col_r   <= '0;
      run_row_r   <= '0;
      run_ch_r    <= '0;
      run_sum_r   <= '0;
    end else if (s2_fire) begin
      if (merged_r.tag.last) begin
        run_peak_r  <= '0;
        run_valid_r <= 1'b0;
        run_col_r   <= '0;
        run_row_r   <= '0;
        run_ch_r    <= '0;
        run_sum_r   <= '0;
      end else begin
        run_peak_r  <= new_peak;
        run_valid_r <= new_valid;
        run_col_r   <= new_col;
        run_row_r   <= new_row;
        run_ch_r    <= new_ch;
        run_sum_r   <= new_sum;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s2_fire && merged_r.tag.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A frame without any difference reports its location as all ones.
  always_ff @(posedge clk) begin
    if (s2_fire && merged_r.tag.last) begin
      out_peak_difference  <= new_peak;
      out_peak_column      <= new_valid ? $signed({1'b0, new_col}) : '1;
      out_peak_row         <= new_valid ? $signed({1'b0, new_row}) : '1;
      out_peak_channel     <= new_valid ? $signed({1'b0, new_ch}) : '1;
      out_difference_sum   <= new_sum;
      out_within_tolerance <= (new_peak <= tol_r);
    end
  end

endmodule
